// ===== rtl/ect_pkg.sv =====
// Shared constants and types for the event counter table.
package ect_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int GRP_SZ  = 8;
	localparam int LOC_W   = $clog2(GRP_SZ);
	localparam int NGRP    = (ENTRIES + GRP_SZ - 1) / GRP_SZ;

	localparam logic [63:0] CNT_MAX    = 64'hffff_ffff_ffff_fffe;
	localparam logic [63:0] ALL_ONES   = 64'hffff_ffff_ffff_ffff;
	localparam logic [15:0] BASE_RESET = 16'd256;
	localparam logic [3:0]  MIN_BYTES  = 4'd8;

	localparam logic [2:0] OP_CREATE = 3'd0;
	localparam logic [2:0] OP_CLOSE  = 3'd1;
	localparam logic [2:0] OP_READ   = 3'd2;
	localparam logic [2:0] OP_WRITE  = 3'd3;
	localparam logic [2:0] OP_STATUS = 3'd4;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NOFREE = 3'd1;
	localparam logic [2:0] ST_BADH   = 3'd2;
	localparam logic [2:0] ST_INVAL  = 3'd3;
	localparam logic [2:0] ST_BLOCK  = 3'd4;
	localparam logic [2:0] ST_WAIT   = 3'd5;

	localparam int MODE_NONBLOCK = 0;
	localparam int MODE_SEM      = 1;

	typedef struct packed {
		logic capture;
		logic commit;
	} ect_cmd_t;

endpackage

// ===== rtl/event_counter_table_top.sv =====
// Top level of the event counter table.
//
// Input channel: in_valid / in_stall with opcode, handle, data_value,
// mode_flags, byte_count. An item is taken when in_valid is high and
// in_stall is low. Output channel: out_valid / out_stall with status,
// new_handle, read_value, readable, writable; one result per item.
// handle_base is written through cfg_wr_en / cfg_wr_data; the user must
// do so only while idle, as the block itself does not enforce it.
//
// The accept edge reads the counter RAM; the commit edge, in execute,
// checks, updates the entry and loads the result register. Because of
// the RAM read-modify-write, no new item is taken until the current one
// has committed. The free-entry search uses a registered group summary
// of the in-use bits.
// If the receiver stalls, a finished result waits in the output
// register; one more item may be taken and then holds in execute.
// Reset clears all in-use bits and sets handle_base to 256.
module event_counter_table_top import ect_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [15:0] handle,
	input  logic [63:0] data_value,
	input  logic [1:0]  mode_flags,
	input  logic [3:0]  byte_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] new_handle,
	output logic [63:0] read_value,
	output logic        readable,
	output logic        writable
);

	ect_cmd_t cmd;

	ect_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ect_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.opcode      (opcode),
		.handle      (handle),
		.data_value  (data_value),
		.mode_flags  (mode_flags),
		.byte_count  (byte_count),
		.status      (status),
		.new_handle  (new_handle),
		.read_value  (read_value),
		.readable    (readable),
		.writable    (writable)
	);

endmodule

// ===== rtl/ect_ctrl.sv =====
// Control state machine: input handshake, execute sequencing, output valid.
module ect_ctrl import ect_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output ect_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   go;

	assign in_stall    = (state_q != S_IDLE);
	assign accept      = in_valid && !in_stall;
	assign go          = (state_q == S_EXEC) && (!out_valid_q || !out_stall);
	assign cmd.capture = accept;
	assign cmd.commit  = go;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted item did not enter execute");

	a_exec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && !go |=> (state_q == S_EXEC))
		else $error("execute left without committing");

	a_go_valid: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> out_valid_q)
		else $error("committed result not presented");

endmodule

// ===== rtl/ect_dpath.sv =====
// Datapath: counter and mode memories, in-use bits, free-entry search, result registers.
module ect_dpath import ect_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ect_cmd_t    cmd,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic [2:0]  opcode,
	input  logic [15:0] handle,
	input  logic [63:0] data_value,
	input  logic [1:0]  mode_flags,
	input  logic [3:0]  byte_count,
	output logic [2:0]  status,
	output logic [15:0] new_handle,
	output logic [63:0] read_value,
	output logic        readable,
	output logic        writable
);

	logic [63:0] count_mem [ENTRIES];
	logic [1:0]  mode_mem  [ENTRIES];

	logic [15:0]        handle_base_q;
	logic [ENTRIES-1:0] in_use_q;
	logic [NGRP-1:0]    grp_free_q;
	logic [LOC_W-1:0]   grp_loc_q [NGRP];
	logic [NGRP-1:0]    grp_free_n;
	logic [LOC_W-1:0]   grp_loc_n [NGRP];

	logic [2:0]  op_q;
	logic [15:0] idx_q;
	logic [63:0] val_q;
	logic [1:0]  flags_q;
	logic [3:0]  bytes_q;
	logic [63:0] count_rd_q;
	logic [1:0]  mode_rd_q;

	logic [15:0] rd_idx;
	logic        free_any;
	logic [15:0] free_idx;
	logic        hit;
	logic [2:0]  stall_st;
	logic [64:0] sum;
	logic        ovf;

	logic [2:0]  st_n;
	logic [15:0] nh_n;
	logic [63:0] rv_n;
	logic        rd_n;
	logic        wr_n;
	logic        mem_we;
	logic        mode_we;
	logic [IDX_W-1:0] waddr;
	logic [63:0] wdata;
	logic        set_use;
	logic        clr_use;

	assign rd_idx   = handle - handle_base_q;
	assign hit      = (idx_q < 16'(ENTRIES)) && in_use_q[idx_q[IDX_W-1:0]];
	assign stall_st = mode_rd_q[MODE_NONBLOCK] ? ST_BLOCK : ST_WAIT;
	assign sum      = {1'b0, count_rd_q} + {1'b0, val_q};
	assign ovf      = sum > {1'b0, CNT_MAX};

	// lowest group with a free entry, from the registered group summary
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_free_q[g]) begin
				free_any = 1'b1;
				free_idx = 16'(g * GRP_SZ) + 16'(grp_loc_q[g]);
			end
		end
	end

	// per group: any free slot, and the lowest free slot
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_free_n[g] = 1'b0;
			grp_loc_n[g]  = '0;
			for (int k = GRP_SZ - 1; k >= 0; k--) begin
				if (g * GRP_SZ + k < ENTRIES) begin
					if (!in_use_q[g * GRP_SZ + k]) begin
						grp_free_n[g] = 1'b1;
						grp_loc_n[g]  = LOC_W'(k);
					end
				end
			end
		end
	end

	always_comb begin
		st_n    = ST_OK;
		nh_n    = '0;
		rv_n    = '0;
		rd_n    = 1'b0;
		wr_n    = 1'b0;
		mem_we  = 1'b0;
		mode_we = 1'b0;
		waddr   = idx_q[IDX_W-1:0];
		wdata   = count_rd_q;
		set_use = 1'b0;
		clr_use = 1'b0;
		case (op_q)
			OP_CREATE: begin
				if (!free_any) begin
					st_n = ST_NOFREE;
				end else begin
					waddr   = free_idx[IDX_W-1:0];
					wdata   = (val_q > CNT_MAX) ? CNT_MAX : val_q;
					mem_we  = 1'b1;
					mode_we = 1'b1;
					set_use = 1'b1;
					nh_n    = handle_base_q + free_idx;
				end
			end
			OP_CLOSE: begin
				if (!hit) begin
					st_n = ST_BADH;
				end else begin
					clr_use = 1'b1;
				end
			end
			OP_READ: begin
				if (!hit) begin
					st_n = ST_BADH;
				end else if (bytes_q < MIN_BYTES) begin
					st_n = ST_INVAL;
				end else if (count_rd_q == '0) begin
					st_n = stall_st;
				end else if (mode_rd_q[MODE_SEM]) begin
					rv_n   = 64'd1;
					wdata  = count_rd_q - 64'd1;
					mem_we = 1'b1;
				end else begin
					rv_n   = count_rd_q;
					wdata  = '0;
					mem_we = 1'b1;
				end
			end
			OP_WRITE: begin
				if (!hit) begin
					st_n = ST_BADH;
				end else if (bytes_q < MIN_BYTES || val_q == ALL_ONES) begin
					st_n = ST_INVAL;
				end else if (ovf) begin
					st_n = stall_st;
				end else begin
					wdata  = sum[63:0];
					mem_we = 1'b1;
				end
			end
			OP_STATUS: begin
				if (!hit) begin
					st_n = ST_BADH;
				end else begin
					rd_n = (count_rd_q != '0);
					wr_n = (count_rd_q != CNT_MAX);
				end
			end
			default: st_n = ST_INVAL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handle_base_q <= BASE_RESET;
			in_use_q      <= '0;
			grp_free_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				handle_base_q <= cfg_wr_data;
			end
			if (cmd.commit && set_use) begin
				in_use_q[waddr] <= 1'b1;
			end
			if (cmd.commit && clr_use) begin
				in_use_q[waddr] <= 1'b0;
			end
			grp_free_q <= grp_free_n;
		end
	end

	// local lowest free slot of each group
	always_ff @(posedge clk) begin
		grp_loc_q <= grp_loc_n;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= opcode;
			idx_q      <= rd_idx;
			val_q      <= data_value;
			flags_q    <= mode_flags;
			bytes_q    <= byte_count;
			count_rd_q <= count_mem[rd_idx[IDX_W-1:0]];
			mode_rd_q  <= mode_mem[rd_idx[IDX_W-1:0]];
		end
		if (cmd.commit && mem_we) begin
			count_mem[waddr] <= wdata;
		end
		if (cmd.commit && mode_we) begin
			mode_mem[waddr] <= flags_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status     <= st_n;
			new_handle <= nh_n;
			read_value <= rv_n;
			readable   <= rd_n;
			writable   <= wr_n;
		end
	end

	a_create_sets: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && set_use |=> in_use_q[$past(waddr)])
		else $error("create did not mark entry in use");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && clr_use |=> !in_use_q[$past(waddr)])
		else $error("close did not release entry");

	a_capture_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !cmd.commit)
		else $error("capture and commit in one cycle");

endmodule

// ===== tb/ect_monitor.sv =====
// Event counter table monitor: watches both channels, predicts each reply and compares it.
`timescale 1ns / 1ps

module ect_monitor import ect_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [15:0] handle,
	input  logic [63:0] data_value,
	input  logic [1:0]  mode_flags,
	input  logic [3:0]  byte_count,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [15:0] new_handle,
	input  logic [63:0] read_value,
	input  logic        readable,
	input  logic        writable,
	output int          fail_count,
	output int          pending,
	output int          checked
);

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] new_handle;
		logic [63:0] read_value;
		logic        readable;
		logic        writable;
	} reply_t;

	logic [15:0] base;
	logic        live [ENTRIES];
	logic [63:0] cnt_mem [ENTRIES];
	logic [1:0]  mode_mem [ENTRIES];
	reply_t      replies_due [$];
	reply_t      want;

	function automatic logic [2:0] wait_status(input int slot);
		return mode_mem[slot][MODE_NONBLOCK] ? ST_BLOCK : ST_WAIT;
	endfunction

	function automatic reply_t execute_request(input logic [2:0] op, input logic [15:0] h,
			input logic [63:0] amount, input logic [1:0] flags, input logic [3:0] nbytes);
		reply_t      r;
		logic [15:0] offset;
		logic        hit;
		int          slot;
		int          i;
		r = '0;
		offset = h - base;
		slot = int'(offset);
		hit = (offset < 16'(ENTRIES)) ? live[offset[IDX_W-1:0]] : 1'b0;
		case (op)
		OP_CREATE: begin
			slot = -1;
			for (i = ENTRIES - 1; i >= 0; i--)
				if (!live[i]) slot = i;
			if (slot < 0) begin
				r.status = ST_NOFREE;
			end else begin
				live[slot] = 1'b1;
				cnt_mem[slot] = (amount > CNT_MAX) ? CNT_MAX : amount;
				mode_mem[slot] = flags;
				r.new_handle = base + 16'(slot);
			end
		end
		OP_CLOSE: begin
			if (!hit) begin
				r.status = ST_BADH;
			end else begin
				live[slot] = 1'b0;
				cnt_mem[slot] = '0;
				mode_mem[slot] = '0;
			end
		end
		OP_READ: begin
			if (!hit) begin
				r.status = ST_BADH;
			end else if (nbytes < MIN_BYTES) begin
				r.status = ST_INVAL;
			end else if (cnt_mem[slot] == '0) begin
				r.status = wait_status(slot);
			end else if (mode_mem[slot][MODE_SEM]) begin
				r.read_value = 64'd1;
				cnt_mem[slot] = cnt_mem[slot] - 64'd1;
			end else begin
				r.read_value = cnt_mem[slot];
				cnt_mem[slot] = '0;
			end
		end
		OP_WRITE: begin
			if (!hit) begin
				r.status = ST_BADH;
			end else if (nbytes < MIN_BYTES || amount == ALL_ONES) begin
				r.status = ST_INVAL;
			end else if (CNT_MAX - cnt_mem[slot] < amount) begin
				r.status = wait_status(slot);
			end else begin
				cnt_mem[slot] = cnt_mem[slot] + amount;
			end
		end
		OP_STATUS: begin
			if (!hit) begin
				r.status = ST_BADH;
			end else begin
				r.readable = (cnt_mem[slot] != '0);
				r.writable = (cnt_mem[slot] < CNT_MAX);
			end
		end
		default: begin
			r.status = ST_INVAL;
		end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base = BASE_RESET;
			for (int i = 0; i < ENTRIES; i++) begin
				live[i] = 1'b0;
				cnt_mem[i] = '0;
				mode_mem[i] = '0;
			end
			replies_due.delete();
			fail_count = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en)
				base = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("reply with no request outstanding: status %0d", status);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					checked++;
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (new_handle !== want.new_handle) begin
						$error("new_handle mismatch: expected %0d, got %0d",
							want.new_handle, new_handle);
						fail_count++;
					end
					if (read_value !== want.read_value) begin
						$error("read_value mismatch: expected %0h, got %0h",
							want.read_value, read_value);
						fail_count++;
					end
					if (readable !== want.readable) begin
						$error("readable mismatch: expected %0b, got %0b",
							want.readable, readable);
						fail_count++;
					end
					if (writable !== want.writable) begin
						$error("writable mismatch: expected %0b, got %0b",
							want.writable, writable);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(execute_request(opcode, handle, data_value,
					mode_flags, byte_count));
			pending = replies_due.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Event counter table testbench top: clock, reset, request stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
	import ect_pkg::*;

	localparam int          STUCK_LIMIT = 4000;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          PHASE_ITEMS = 180;
	localparam logic [1:0]  FL_NB = 2'(1 << MODE_NONBLOCK);
	localparam logic [1:0]  FL_SEM = 2'(1 << MODE_SEM);
	localparam logic [15:0] BASE_TOP = 16'd65472;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  opcode;
	logic [15:0] handle;
	logic [63:0] data_value;
	logic [1:0]  mode_flags;
	logic [3:0]  byte_count;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [15:0] new_handle;
	logic [63:0] read_value;
	logic        readable;
	logic        writable;

	int          fail_count;
	int          pending;
	int          checked;
	int          stuck_cycles;
	int          tx_idle;
	int          rx_idle;
	int          items_sent;
	int          base_writes;
	logic [15:0] cur_base;

	event_counter_table_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.handle     (handle),
		.data_value (data_value),
		.mode_flags (mode_flags),
		.byte_count (byte_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.new_handle (new_handle),
		.read_value (read_value),
		.readable   (readable),
		.writable   (writable)
	);

	ect_monitor mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.handle     (handle),
		.data_value (data_value),
		.mode_flags (mode_flags),
		.byte_count (byte_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.new_handle (new_handle),
		.read_value (read_value),
		.readable   (readable),
		.writable   (writable),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
		$display("tb_top failed");
		$finish;
	end

	task automatic send(input logic [2:0] op, input logic [15:0] h, input logic [63:0] v,
			input logic [1:0] fl, input logic [3:0] nb);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		handle <= h;
		data_value <= v;
		mode_flags <= fl;
		byte_count <= nb;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// hold off the sender until every reply is back
	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_base(input logic [15:0] b);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= b;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_base = b;
		base_writes++;
	endtask

	function automatic logic [15:0] pick_handle;
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return cur_base + 16'($urandom_range(0, 15));
		else if (r < 80)
			return cur_base + 16'($urandom_range(0, ENTRIES - 1));
		else if (r < 88)
			return cur_base + 16'($urandom_range(ENTRIES, ENTRIES + 16));
		return 16'($urandom);
	endfunction

	function automatic logic [63:0] pick_value;
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 64'($urandom_range(0, 20));
		else if (r < 55)
			return CNT_MAX - 64'($urandom_range(0, 20));
		else if (r < 60)
			return ALL_ONES;
		return {$urandom, $urandom};
	endfunction

	// mix: 0 create-heavy, 1 balanced, 2 read/write-heavy, 3 close-heavy
	task automatic send_random(input int mix);
		int         r;
		int         c_cr;
		int         c_cl;
		int         c_rd;
		int         c_wr;
		int         c_st;
		logic [2:0] op;
		case (mix)
		0: begin
			c_cr = 60; c_cl = 65; c_rd = 75; c_wr = 85; c_st = 95;
		end
		1: begin
			c_cr = 20; c_cl = 35; c_rd = 60; c_wr = 80; c_st = 95;
		end
		2: begin
			c_cr = 5; c_cl = 10; c_rd = 50; c_wr = 85; c_st = 98;
		end
		default: begin
			c_cr = 5; c_cl = 55; c_rd = 70; c_wr = 80; c_st = 95;
		end
		endcase
		r = $urandom_range(0, 99);
		if (r < c_cr)
			op = OP_CREATE;
		else if (r < c_cl)
			op = OP_CLOSE;
		else if (r < c_rd)
			op = OP_READ;
		else if (r < c_wr)
			op = OP_WRITE;
		else if (r < c_st)
			op = OP_STATUS;
		else
			op = 3'($urandom_range(OP_STATUS + 1, 7));
		send(op, pick_handle(), pick_value(), 2'($urandom_range(0, 3)),
			($urandom_range(0, 99) < 80) ? MIN_BYTES : 4'($urandom_range(0, 7)));
	endtask

	task automatic run_random(input int tx, input int rx);
		tx_idle = tx;
		rx_idle = rx;
		for (int k = 0; k < PHASE_ITEMS; k++)
			send_random((k / 45) % 4);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		opcode = OP_CREATE;
		handle = '0;
		data_value = '0;
		mode_flags = '0;
		byte_count = '0;
		tx_idle = 34;
		rx_idle = 66;
		items_sent = 0;
		base_writes = 0;
		cur_base = BASE_RESET;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: saturation, blocking vs nonblocking, semaphore, bad args
		send(OP_CREATE, '0, 64'd0, 2'b00, '0);
		send(OP_CREATE, '0, ALL_ONES, FL_NB, '0);
		send(OP_CREATE, '0, 64'd5, FL_SEM | FL_NB, '0);
		send(OP_CREATE, '0, 64'd0, FL_NB, '0);
		send(OP_READ, cur_base, '0, '0, MIN_BYTES);
		send(OP_READ, cur_base + 16'd3, '0, '0, MIN_BYTES);
		send(OP_STATUS, cur_base, '0, '0, '0);
		send(OP_STATUS, cur_base + 16'd1, '0, '0, '0);
		send(OP_WRITE, cur_base + 16'd1, 64'd1, '0, MIN_BYTES);
		send(OP_WRITE, cur_base, ALL_ONES, '0, MIN_BYTES);
		send(OP_WRITE, cur_base, CNT_MAX, '0, MIN_BYTES);
		send(OP_READ, cur_base, '0, '0, MIN_BYTES - 4'd1);
		send(OP_READ, cur_base, '0, '0, MIN_BYTES);
		send(OP_READ, cur_base + 16'd2, '0, '0, MIN_BYTES);
		send(OP_WRITE, cur_base, 64'd7, '0, 4'd0);
		send(OP_STATUS, cur_base + 16'(ENTRIES), '0, '0, '0);
		send(OP_READ, 16'hffff, '0, '0, MIN_BYTES);
		send(OP_CLOSE, cur_base + 16'd3, '0, '0, '0);
		send(OP_CLOSE, cur_base + 16'd3, '0, '0, '0);
		send(OP_STATUS + 3'd1, '0, ALL_ONES, 2'b11, 4'hf);
		send(OP_STATUS + 3'd2, 16'hffff, '0, '0, MIN_BYTES);
		send(OP_STATUS + 3'd3, '0, '0, '0, '0);
		send(OP_READ, cur_base + 16'd1, '0, '0, MIN_BYTES);

		set_base(16'd0);
		run_random(34, 66);
		set_base(BASE_TOP);
		run_random(66, 34);
		set_base(16'($urandom_range(0, BASE_TOP)));
		run_random(0, 0);

		drain();
		$display("Sent %0d requests across %0d handle_base settings and three stall mixes;",
			items_sent, base_writes + 1);
		$display("%0d replies compared against the prediction.", checked);
		if (fail_count == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ect_pkg.sv
rtl/ect_ctrl.sv
rtl/ect_dpath.sv
rtl/event_counter_table_top.sv
tb/ect_monitor.sv
tb/tb_top.sv
